[sv/calendar_date_offset_engine_core_macros.svh]
// Assertion macros for the calendar date offset engine.
// Included by the top level; no other dependencies.
`ifndef CALENDAR_DATE_OFFSET_ENGINE_CORE_MACROS_SVH
`define CALENDAR_DATE_OFFSET_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CDOE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define CDOE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CDOE_ASSERT_SAME(label, clk, rst, ante, cons)
`define CDOE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[sv/cdoe_pkg.sv]
// Shared types, constants and calendar tables for the date offset engine.
// No dependencies.
package cdoe_pkg;

  localparam int unsigned IDX_W          = 15;
  localparam int unsigned YOFF_W         = 7;
  localparam int unsigned MAX_OFFSET_DEF = 7300;
  localparam logic [10:0] BASE_YEAR      = 11'd1976;
  localparam logic [11:0] YEAR_LO        = 12'd2001;
  localparam logic [11:0] YEAR_HI        = 12'd2020;
  localparam logic [3:0]  LAST_MONTH     = 4'd12;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_SUB  = 2'd1;
  localparam logic [1:0] OP_DIFF = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] year_a;
    logic [3:0]  month_a;
    logic [4:0]  day_a;
    logic [12:0] offset_days;
    logic [11:0] year_b;
    logic [3:0]  month_b;
    logic [4:0]  day_b;
  } cdoe_in_t;

  typedef struct packed {
    logic [10:0] res_year;
    logic [3:0]  res_month;
    logic [4:0]  res_day;
    logic [12:0] day_span;
  } cdoe_out_t;

  // Date produced by the walker.
  typedef struct packed {
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } cdoe_date_t;

  // Days in a month; anything that is not a 30-day month or February has 31.
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      4'd2:                    month_len = leap ? 5'd29 : 5'd28;
      default:                 month_len = 5'd31;
    endcase
  endfunction

  // Days of the year that come before the first of a month.
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
    logic [8:0] base;
    case (m)
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    month_start = base + ((leap && m > 4'd2) ? 9'd1 : 9'd0);
  endfunction

endpackage

[sv/cdoe_index.sv]
// Repairs one date and turns it into a day number counted from 1976-01-01.
// Depends on cdoe_pkg.
module cdoe_index (
  input  logic [11:0]                year,
  input  logic [3:0]                 month,
  input  logic [4:0]                 day,
  output logic [cdoe_pkg::IDX_W-1:0] idx
);
  import cdoe_pkg::*;

  logic [11:0]      yy;
  logic [11:0]      ydelta;
  logic [5:0]       n;
  logic             leap;
  logic [3:0]       mm;
  logic [4:0]       dd;
  logic [IDX_W-1:0] yr_days;
  logic [IDX_W-1:0] leap_days;

  // Repair year, month and day in that order; the day check needs both.
  always_comb begin
    yy     = (year < YEAR_LO || year > YEAR_HI) ? YEAR_HI : year;
    ydelta = yy - {1'b0, BASE_YEAR};
    n      = ydelta[5:0];
    leap   = (yy[1:0] == 2'b00);
    mm     = (month < 4'd1 || month > LAST_MONTH) ? 4'd1 : month;
    dd     = (day == 5'd0 || day > month_len(leap, mm)) ? 5'd1 : day;
  end

  // Whole years, the leap days among them, then the months and days.
  always_comb begin
    yr_days   = IDX_W'(n) * IDX_W'(365);
    leap_days = IDX_W'((7'(n) + 7'd3) >> 2);
    idx       = yr_days + leap_days + IDX_W'(month_start(leap, mm)) + IDX_W'(dd) - IDX_W'(1);
  end

endmodule

[sv/cdoe_walk.sv]
// Turns a day number back into a date by repeated subtraction of year and
// month lengths through one shared compare-and-subtract unit. Depends on cdoe_pkg.
module cdoe_walk (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cdoe_pkg::IDX_W-1:0] target,
  output logic                       done,
  output cdoe_pkg::cdoe_date_t       date
);
  import cdoe_pkg::*;

  typedef enum logic [1:0] {
    W_IDLE,
    W_YEAR,
    W_MONTH
  } walk_state_t;

  walk_state_t       state;
  logic [IDX_W-1:0]  rem;
  logic [YOFF_W-1:0] yoff;
  logic [3:0]        mm;
  logic              leap;
  logic [IDX_W-1:0]  len;
  logic [IDX_W:0]    diff;
  logic              fits;

  // Shared unit: compare the remainder with the current year or month length.
  always_comb begin
    leap = (yoff[1:0] == 2'b00);
    len  = (state == W_YEAR) ? (leap ? IDX_W'(366) : IDX_W'(365))
                             : IDX_W'(month_len(leap, mm));
    diff = {1'b0, rem} - {1'b0, len};
    fits = !diff[IDX_W];
  end

  // Sequencer: years first, then months, then the day is what is left.
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= W_IDLE;
    end else begin
      case (state)
        W_IDLE: begin
          if (start) begin
            rem   <= target;
            yoff  <= '0;
            mm    <= 4'd1;
            state <= W_YEAR;
          end
        end
        W_YEAR: begin
          if (fits) begin
            rem  <= diff[IDX_W-1:0];
            yoff <= yoff + YOFF_W'(1);
          end else begin
            state <= W_MONTH;
          end
        end
        W_MONTH: begin
          if (mm < LAST_MONTH && fits) begin
            rem <= diff[IDX_W-1:0];
            mm  <= mm + 4'd1;
          end else begin
            date.year  <= BASE_YEAR + 11'(yoff);
            date.month <= mm;
            date.day   <= rem[4:0] + 5'd1;
            done       <= 1'b1;
            state      <= W_IDLE;
          end
        end
        default: state <= W_IDLE;
      endcase
    end
  end

endmodule

[sv/calendar_date_offset_engine_core.sv]
// Calendar date offset engine, top level. Uses cdoe_pkg, cdoe_index, cdoe_walk
// and the assertion macros header.
//
// The req channel (valid/ready) carries one item: an opcode, a first date,
// a day count and a second date. The rsp channel (valid/ready) returns one
// result item for each request. Add and subtract move the repaired first date
// by the saturated count; the difference returns the absolute day count
// between the two repaired dates. An unused opcode returns all zeros.
// The block takes one item at a time: req_ready is high only while idle.
// From acceptance the sequencer passes through the index state to the finish
// state for the difference and the unused opcode; add and subtract also pass
// through the walk state, which lasts as long as the year-and-month walk
// through the single subtractor in cdoe_walk, and so grows with the years
// from 1976 to the result and with its month.
// The next item can be accepted in the cycle after a result is loaded.
// A finished result sits in the rsp register; the next request is accepted
// while it waits, and a new result is held back until the old one is taken.
// Synchronous reset returns the sequencers to idle and drops rsp_valid.
module calendar_date_offset_engine_core #(
  parameter int unsigned MAX_OFFSET = cdoe_pkg::MAX_OFFSET_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  cdoe_pkg::cdoe_in_t  req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output cdoe_pkg::cdoe_out_t rsp
);
  import cdoe_pkg::*;

`include "calendar_date_offset_engine_core_macros.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INDEX,
    ST_WALK,
    ST_FINISH
  } core_state_t;

  core_state_t      state;
  cdoe_in_t         item;
  cdoe_out_t        pending;
  logic [IDX_W-1:0] ia;
  logic [IDX_W-1:0] ib;
  logic [12:0]      cnt;
  logic [IDX_W-1:0] target;
  logic [12:0]      span;
  logic             walk_start;
  logic             walk_done;
  cdoe_date_t       walk_date;

  cdoe_index u_index_a (
    .year  (item.year_a),
    .month (item.month_a),
    .day   (item.day_a),
    .idx   (ia)
  );

  cdoe_index u_index_b (
    .year  (item.year_b),
    .month (item.month_b),
    .day   (item.day_b),
    .idx   (ib)
  );

  cdoe_walk u_walk (
    .clk    (clk),
    .rst    (rst),
    .start  (walk_start),
    .target (target),
    .done   (walk_done),
    .date   (walk_date)
  );

  // Saturated count, moved day number and absolute difference.
  always_comb begin
    cnt        = (item.offset_days > 13'(MAX_OFFSET)) ? 13'(MAX_OFFSET) : item.offset_days;
    target     = (item.opcode == OP_SUB) ? (ia - IDX_W'(cnt)) : (ia + IDX_W'(cnt));
    span       = (ia >= ib) ? 13'(ia - ib) : 13'(ib - ia);
    walk_start = (state == ST_INDEX) && (item.opcode == OP_ADD || item.opcode == OP_SUB);
    req_ready  = (state == ST_IDLE);
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != ST_FINISH) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            item  <= req;
            state <= ST_INDEX;
          end
        end
        ST_INDEX: begin
          if (item.opcode == OP_ADD || item.opcode == OP_SUB) begin
            state <= ST_WALK;
          end else if (item.opcode == OP_DIFF) begin
            pending <= {11'd0, 4'd0, 5'd0, span};
            state   <= ST_FINISH;
          end else begin
            pending <= '0;
            state   <= ST_FINISH;
          end
        end
        ST_WALK: begin
          if (walk_done) begin
            pending.res_year  <= walk_date.year;
            pending.res_month <= walk_date.month;
            pending.res_day   <= walk_date.day;
            pending.day_span  <= '0;
            state             <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= pending;
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks on the sequencing and on the result item.
  `CDOE_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready)
  `CDOE_ASSERT_SAME(a_walk_done_in_walk, clk, rst, walk_done, state == ST_WALK)
  `CDOE_ASSERT_SAME(a_span_only_diff, clk, rst, rsp_valid && rsp.day_span != 13'd0, rsp.res_year == 11'd0 && rsp.res_month == 4'd0)
  `CDOE_ASSERT_SAME(a_month_legal, clk, rst, rsp_valid && rsp.res_year != 11'd0, rsp.res_month >= 4'd1 && rsp.res_month <= LAST_MONTH)

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for calendar_date_offset_engine_core.
// Depends on cdoe_pkg and the engine RTL. Results are checked against a
// built-in date predictor, with random idling on both the req and rsp channels.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdoe_pkg::*;

  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned COUNT_LIMIT  = MAX_OFFSET_DEF;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned HOLD_OFF     = 400;
  localparam int unsigned SETTLE       = 100;

  // One row of the directed table; typed rows carry their result spelled out.
  typedef struct packed {
    cdoe_in_t  item;
    logic      typed;
    cdoe_out_t result;
  } date_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  cdoe_in_t  req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  cdoe_out_t rsp;

  cdoe_out_t   date_results_due[$];
  date_row_t   directed_rows[$];
  cdoe_out_t   oldest_due;
  int unsigned mismatch_count = 0;
  int unsigned results_taken = 0;
  int unsigned quiet_cycles = 0;
  bit          held_off = 1'b0;

  calendar_date_offset_engine_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Days in a month; every fourth year is a leap year.
  function automatic int unsigned month_days(input int unsigned yr, input int unsigned mo);
    if (mo == 4 || mo == 6 || mo == 9 || mo == 11) begin
      return 30;
    end
    if (mo == 2) begin
      return (yr % 4 == 0) ? 29 : 28;
    end
    return 31;
  endfunction

  // Repairs a raw date, then counts its days from the first of January 1976.
  function automatic int unsigned day_number(input logic [11:0] y_raw,
                                             input logic [3:0] m_raw,
                                             input logic [4:0] d_raw);
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    int unsigned yrs;
    int unsigned num;
    int unsigned k;
    yr = y_raw;
    mo = m_raw;
    dy = d_raw;
    if (yr < YEAR_LO || yr > YEAR_HI) begin
      yr = YEAR_HI;
    end
    if (mo < 1 || mo > 12) begin
      mo = 1;
    end
    if (dy < 1 || dy > month_days(yr, mo)) begin
      dy = 1;
    end
    yrs = yr - BASE_YEAR;
    num = yrs * 365 + (yrs + 3) / 4;
    for (k = 1; k < mo; k++) begin
      num += month_days(yr, k);
    end
    return num + dy - 1;
  endfunction

  // Expected result item for one request item.
  function automatic cdoe_out_t calc_date_result(input cdoe_in_t item);
    cdoe_out_t   res;
    int unsigned count;
    int unsigned first;
    int unsigned second;
    int unsigned target;
    int unsigned yr;
    int unsigned mo;
    res = '0;
    count = item.offset_days;
    if (count > COUNT_LIMIT) begin
      count = COUNT_LIMIT;
    end
    first = day_number(item.year_a, item.month_a, item.day_a);
    second = day_number(item.year_b, item.month_b, item.day_b);
    case (item.opcode)
      OP_ADD, OP_SUB: begin
        target = (item.opcode == OP_ADD) ? first + count : first - count;
        yr = BASE_YEAR;
        mo = 1;
        while (target >= ((yr % 4 == 0) ? 366 : 365)) begin
          target -= (yr % 4 == 0) ? 366 : 365;
          yr++;
        end
        while (mo < 12 && target >= month_days(yr, mo)) begin
          target -= month_days(yr, mo);
          mo++;
        end
        res.res_year = 11'(yr);
        res.res_month = 4'(mo);
        res.res_day = 5'(target + 1);
      end
      OP_DIFF: begin
        res.day_span = 13'((first >= second) ? first - second : second - first);
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic cdoe_in_t pack_item(input logic [1:0] op, input logic [11:0] ya,
                                         input logic [3:0] ma, input logic [4:0] da,
                                         input logic [12:0] cnt, input logic [11:0] yb,
                                         input logic [3:0] mb, input logic [4:0] db);
    cdoe_in_t item;
    item.opcode = op;
    item.year_a = ya;
    item.month_a = ma;
    item.day_a = da;
    item.offset_days = cnt;
    item.year_b = yb;
    item.month_b = mb;
    item.day_b = db;
    return item;
  endfunction

  function automatic cdoe_out_t pack_date(input int unsigned yr, input int unsigned mo,
                                          input int unsigned dy, input int unsigned span);
    cdoe_out_t res;
    res.res_year = 11'(yr);
    res.res_month = 4'(mo);
    res.res_day = 5'(dy);
    res.day_span = 13'(span);
    return res;
  endfunction

  task automatic add_row(input cdoe_in_t item, input logic typed, input cdoe_out_t res);
    date_row_t row;
    row.item = item;
    row.typed = typed;
    row.result = res;
    directed_rows.push_back(row);
  endtask

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      return 0;
    end
    if (pick < 90) begin
      return $urandom_range(3, 1);
    end
    if (pick < 97) begin
      return $urandom_range(12, 4);
    end
    return $urandom_range(90, 30);
  endfunction

  // Years mostly in the valid window, some at its edges, some anywhere.
  function automatic logic [11:0] rand_year();
    case ($urandom_range(9))
      0: return 12'($urandom_range(4095));
      1: return $urandom_range(1) ? 12'd2000 + 12'($urandom_range(1)) :
                                    12'd2020 + 12'($urandom_range(1));
      default: return 12'($urandom_range(2020, 2001));
    endcase
  endfunction

  function automatic logic [3:0] rand_month();
    return ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(12, 1));
  endfunction

  function automatic logic [4:0] rand_day();
    return ($urandom_range(7) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(31, 1));
  endfunction

  function automatic logic [12:0] rand_count();
    case ($urandom_range(4))
      0, 1: return 13'($urandom_range(400));
      2, 3: return 13'($urandom_range(COUNT_LIMIT));
      default: return 13'($urandom_range(8191, 7000));
    endcase
  endfunction

  function automatic logic [1:0] rand_opcode();
    if ($urandom_range(15) == 0) begin
      return OP_UNUSED;
    end
    case ($urandom_range(2))
      0: return OP_ADD;
      1: return OP_SUB;
      default: return OP_DIFF;
    endcase
  endfunction

  // Offers one item, records its expected result once taken, then idles.
  task automatic offer_item(input cdoe_in_t item, input logic typed,
                            input cdoe_out_t typed_res);
    int unsigned gap;
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    date_results_due.push_back(typed ? typed_res : calc_date_result(item));
    gap = idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering until every outstanding result has come back.
  task automatic drain_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (date_results_due.size() != 0);
  endtask

  task automatic check_field(input string field, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // Stimulus: reset, the directed table, then random items.
  initial begin
    add_row(pack_item(OP_ADD, 2001, 1, 1, 0, 2001, 1, 1), 1, pack_date(2001, 1, 1, 0));
    add_row(pack_item(OP_SUB, 0, 0, 0, 0, 0, 0, 0), 1, pack_date(2020, 1, 1, 0));
    add_row(pack_item(OP_UNUSED, 4095, 15, 31, 8191, 4095, 15, 31), 1, pack_date(0, 0, 0, 0));
    add_row(pack_item(OP_DIFF, 2001, 1, 1, 0, 2020, 12, 31), 1, pack_date(0, 0, 0, 7304));
    add_row(pack_item(OP_DIFF, 2020, 12, 31, 5, 2001, 1, 1), 1, pack_date(0, 0, 0, 7304));
    add_row(pack_item(OP_DIFF, 2012, 6, 15, 99, 2012, 6, 15), 1, pack_date(0, 0, 0, 0));
    add_row(pack_item(OP_ADD, 2020, 2, 29, 1, 0, 0, 0), 1, pack_date(2020, 3, 1, 0));
    add_row(pack_item(OP_ADD, 2019, 2, 29, 0, 0, 0, 0), 1, pack_date(2019, 2, 1, 0));
    add_row(pack_item(OP_ADD, 2005, 4, 31, 0, 0, 0, 0), 1, pack_date(2005, 4, 1, 0));
    add_row(pack_item(OP_ADD, 2019, 12, 31, 1, 0, 0, 0), 1, pack_date(2020, 1, 1, 0));
    add_row(pack_item(OP_SUB, 2005, 1, 1, 1, 0, 0, 0), 1, pack_date(2004, 12, 31, 0));
    add_row(pack_item(OP_SUB, 2004, 3, 1, 1, 0, 0, 0), 1, pack_date(2004, 2, 29, 0));
    add_row(pack_item(OP_ADD, 2000, 7, 4, 0, 0, 0, 0), 1, pack_date(2020, 7, 4, 0));
    add_row(pack_item(OP_ADD, 2021, 7, 4, 0, 0, 0, 0), 1, pack_date(2020, 7, 4, 0));
    add_row(pack_item(OP_ADD, 2010, 5, 0, 0, 0, 0, 0), 1, pack_date(2010, 5, 1, 0));
    add_row(pack_item(OP_ADD, 2010, 13, 20, 0, 0, 0, 0), 1, pack_date(2010, 1, 20, 0));
    add_row(pack_item(OP_ADD, 2010, 0, 31, 0, 0, 0, 0), 1, pack_date(2010, 1, 31, 0));
    // The rows below lean on the predictor.
    add_row(pack_item(OP_ADD, 2020, 12, 31, 8191, 0, 0, 0), 0, '0);
    add_row(pack_item(OP_ADD, 2020, 12, 31, 7300, 0, 0, 0), 0, '0);
    add_row(pack_item(OP_ADD, 2010, 3, 15, 7301, 0, 0, 0), 0, '0);
    add_row(pack_item(OP_SUB, 2001, 1, 1, 8191, 0, 0, 0), 0, '0);
    add_row(pack_item(OP_SUB, 2001, 1, 1, 7299, 0, 0, 0), 0, '0);
    add_row(pack_item(OP_DIFF, 4095, 15, 31, 8191, 4095, 15, 31), 0, '0);
    add_row(pack_item(OP_DIFF, 4095, 15, 31, 0, 2020, 1, 1), 0, '0);
    add_row(pack_item(OP_SUB, 2003, 2, 28, 400, 0, 0, 0), 0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
    end
    drain_results();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      offer_item(pack_item(rand_opcode(), rand_year(), rand_month(), rand_day(),
                           rand_count(), rand_year(), rand_month(), rand_day()), 0, '0);
      if (n == RANDOM_ITEMS / 2) begin
        drain_results();
      end
    end
    drain_results();
    repeat (SETTLE) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS calendar_date_offset_engine_core");
    end else begin
      $display("FAIL calendar_date_offset_engine_core");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off so the engine backs up.
  initial begin
    repeat (4) @(posedge clk);
    forever begin
      if (!held_off && results_taken >= 60) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        held_off = 1'b1;
      end else begin
        rsp_ready <= 1'b1;
        repeat (($urandom_range(9) == 0) ? $urandom_range(150, 50) : $urandom_range(8, 1))
          @(posedge clk);
        if (idle_len() > 0) begin
          rsp_ready <= 1'b0;
          repeat (idle_len() + 1) @(posedge clk);
        end
      end
    end
  end

  // Compare each taken result item with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      results_taken <= results_taken + 1;
      if (date_results_due.size() == 0) begin
        $display("%0t: unexpected result item, expected none, got %h", $time, rsp);
        mismatch_count++;
      end else begin
        oldest_due = date_results_due.pop_front();
        check_field("res_year", oldest_due.res_year, rsp.res_year);
        check_field("res_month", oldest_due.res_month, rsp.res_month);
        check_field("res_day", oldest_due.res_day, rsp.res_day);
        check_field("day_span", oldest_due.day_span, rsp.day_span);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL calendar_date_offset_engine_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[sim.f]
+incdir+sv
sv/cdoe_pkg.sv
sv/cdoe_index.sv
sv/cdoe_walk.sv
sv/calendar_date_offset_engine_core.sv
tb/sv/tb.sv
